[src/ogfq_pkg.sv]
// ----------------------------------------------------------------------------
// ogfq_pkg
// Shared widths, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ogfq_pkg;

    localparam int POS_W = 12;
    localparam int GAP_W = 12;

    typedef logic [3:0] op_t;

    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_CLR      = 4'd1;
    localparam op_t OP_LOAD     = 4'd2;
    localparam op_t OP_LEAF_RD  = 4'd3;
    localparam op_t OP_LEAF_CHK = 4'd4;
    localparam op_t OP_UP       = 4'd5;
    localparam op_t OP_UP_CHK   = 4'd6;
    localparam op_t OP_DN       = 4'd7;
    localparam op_t OP_DN_CHK   = 4'd8;
    localparam op_t OP_EMIT     = 4'd9;
    localparam op_t OP_SUP      = 4'd10;
    localparam op_t OP_SUP_CHK  = 4'd11;
    localparam op_t OP_SDN      = 4'd12;
    localparam op_t OP_SDN_CHK  = 4'd13;
    localparam op_t OP_UPD_WR   = 4'd14;
    localparam op_t OP_UPD_CHK  = 4'd15;

    typedef struct packed {
        op_t  op;
        logic upd_rd;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_skip;
        logic is_query;
        logic root;
        logic n_odd;
        logic d_leaf;
        logic rd_nz;
        logic want_second;
    } status_t;

endpackage

[src/obstacle_gap_fit_query_top.sv]
// ----------------------------------------------------------------------------
// obstacle_gap_fit_query_top
// Obstacle set on a line with a max tree of gaps; answers block fit requests.
// ----------------------------------------------------------------------------
// usage
//   request channel: start/busy command style, a request is taken on a clock
//   edge with start high and busy low; func 0 places an obstacle at position,
//   func 1 asks whether block_size fits in some gap up to position
//   result channel: done pulses for one cycle with fits valid; only func 1
//   requests produce a result; the receiver cannot stall, so done is never
//   held and nothing is buffered
//   timing: the tree walks share the single tree memory port, each walk
//   reading one node at a time
//   query: done comes in the cycle after the last busy cycle
//   place: a place at position 0 or beyond the line is dropped at once
//   without going busy, a place onto an existing obstacle is dropped after
//   the leaf read and its check
//   one request at a time; the walks through the tree memory set the rate
//   reset: busy stays high while every word of the tree is swept to zero,
//   then the block takes requests
// ----------------------------------------------------------------------------
module obstacle_gap_fit_query_top
    import ogfq_pkg::*;
#(
    parameter int POSITIONS = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             func,
    input  logic [POS_W-1:0] position,
    input  logic [POS_W-1:0] block_size,
    output logic             done,
    output logic             fits
);

    cmd_t    cmd;
    status_t st;

    // sequencer
    ogfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    // tree memory and walk registers
    ogfq_dp #(
        .POSITIONS (POSITIONS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .position   (position),
        .block_size (block_size),
        .st         (st),
        .fits       (fits),
        .done       (done)
    );

endmodule

[src/ogfq_ram.sv]
// ----------------------------------------------------------------------------
// ogfq_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ogfq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[src/ogfq_ctrl.sv]
// ----------------------------------------------------------------------------
// ogfq_ctrl
// Sequencer for tree walks: clear, predecessor, successor, update, answer.
// ----------------------------------------------------------------------------
module ogfq_ctrl
    import ogfq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t st,
    output cmd_t    cmd,
    output logic    busy
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LEAF     = 4'd2;
    localparam logic [3:0] S_LEAF_CHK = 4'd3;
    localparam logic [3:0] S_UP       = 4'd4;
    localparam logic [3:0] S_UP_CHK   = 4'd5;
    localparam logic [3:0] S_DN       = 4'd6;
    localparam logic [3:0] S_DN_CHK   = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;
    localparam logic [3:0] S_SUP      = 4'd9;
    localparam logic [3:0] S_SUP_CHK  = 4'd10;
    localparam logic [3:0] S_SDN      = 4'd11;
    localparam logic [3:0] S_SDN_CHK  = 4'd12;
    localparam logic [3:0] S_UPD      = 4'd13;
    localparam logic [3:0] S_UPD_RD   = 4'd14;
    localparam logic [3:0] S_UPD_CHK  = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        cmd.upd_rd = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLR;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (!st.in_skip)
                    begin
                        state_next = S_LEAF;
                    end
                end
            end
            S_LEAF:
            begin
                cmd.op     = OP_LEAF_RD;
                state_next = S_LEAF_CHK;
            end
            S_LEAF_CHK:
            begin
                cmd.op = OP_LEAF_CHK;
                // placing onto an existing obstacle does nothing
                state_next = (!st.is_query && st.rd_nz) ? S_IDLE : S_UP;
            end
            S_UP:
            begin
                cmd.op = OP_UP;
                if (st.root)
                begin
                    state_next = S_DN;
                end
                else if (st.n_odd)
                begin
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK:
            begin
                cmd.op     = OP_UP_CHK;
                state_next = S_UP;
            end
            S_DN:
            begin
                cmd.op = OP_DN;
                if (st.d_leaf)
                begin
                    state_next = st.is_query ? S_EMIT : S_SUP;
                end
                else
                begin
                    state_next = S_DN_CHK;
                end
            end
            S_DN_CHK:
            begin
                cmd.op     = OP_DN_CHK;
                state_next = S_DN;
            end
            S_EMIT:
            begin
                cmd.op     = OP_EMIT;
                state_next = S_IDLE;
            end
            S_SUP:
            begin
                cmd.op = OP_SUP;
                if (st.root)
                begin
                    state_next = S_UPD;
                end
                else if (!st.n_odd)
                begin
                    state_next = S_SUP_CHK;
                end
            end
            S_SUP_CHK:
            begin
                cmd.op     = OP_SUP_CHK;
                state_next = st.rd_nz ? S_SDN : S_SUP;
            end
            S_SDN:
            begin
                cmd.op     = OP_SDN;
                state_next = st.d_leaf ? S_UPD : S_SDN_CHK;
            end
            S_SDN_CHK:
            begin
                cmd.op     = OP_SDN_CHK;
                state_next = S_SDN;
            end
            S_UPD:
            begin
                cmd.op = OP_UPD_WR;
                if (st.root)
                begin
                    state_next = st.want_second ? S_UPD : S_IDLE;
                end
                else
                begin
                    state_next = S_UPD_RD;
                end
            end
            S_UPD_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = S_UPD_CHK;
            end
            S_UPD_CHK:
            begin
                cmd.op     = OP_UPD_CHK;
                state_next = S_UPD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/ogfq_dp.sv]
// ----------------------------------------------------------------------------
// ogfq_dp
// Gap tree memory, node pointers, max accumulator and result register.
// ----------------------------------------------------------------------------
module ogfq_dp
    import ogfq_pkg::*;
#(
    parameter int POSITIONS = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             func,
    input  logic [POS_W-1:0] position,
    input  logic [POS_W-1:0] block_size,
    output status_t          st,
    output logic             fits,
    output logic             done
);

    localparam int AW = $clog2(POSITIONS);
    localparam int NW = AW + 1;

    // tree storage
    logic             we;
    logic [NW-1:0]    addr;
    logic [GAP_W-1:0] wdata;
    logic [GAP_W-1:0] rdata;

    ogfq_ram #(
        .WIDTH (GAP_W),
        .DEPTH (2 ** NW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // control registers
    logic [NW-1:0]    clr_reg,    clr_next;
    logic             found_reg,  found_next;
    logic             nfound_reg, nfound_next;
    logic             second_reg, second_next;
    logic             done_reg,   done_next;
    // payload registers
    logic             func_reg,   func_next;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [POS_W-1:0] size_reg,   size_next;
    logic [AW-1:0]    p_reg,      p_next;
    logic [AW-1:0]    pre_reg,    pre_next;
    logic [AW-1:0]    nxt_reg,    nxt_next;
    logic [NW-1:0]    n_reg,      n_next;
    logic [NW-1:0]    d_reg,      d_next;
    logic [GAP_W-1:0] best_reg,   best_next;
    logic [GAP_W-1:0] val_reg,    val_next;
    logic             fits_reg,   fits_next;

    logic [31:0]      pos32;
    logic [31:0]      clamp32;
    logic [AW-1:0]    pre_new;
    logic [AW-1:0]    nxt_new;
    logic [GAP_W-1:0] gap1;
    logic [GAP_W-1:0] gap2;
    logic [GAP_W-1:0] tail;
    logic [GAP_W-1:0] top;
    logic             rd_nz;

    assign pos32   = 32'(position);
    assign clamp32 = (pos32 < 32'(POSITIONS)) ? pos32 : 32'(POSITIONS - 1);
    assign rd_nz   = (rdata != '0);
    assign pre_new = d_reg[AW-1:0];
    assign nxt_new = d_reg[AW-1:0];
    // new obstacle gap back to its predecessor
    assign gap1    = GAP_W'(32'(pos_reg) - 32'(pre_reg));
    assign gap2    = GAP_W'(32'(nxt_reg) - 32'(pos_reg));
    assign tail    = GAP_W'(32'(pos_reg) - 32'(pre_reg));
    assign top     = (best_reg > tail) ? best_reg : tail;

    assign st.clr_last    = &clr_reg;
    assign st.in_skip     = !func && ((position == '0) || (pos32 >= 32'(POSITIONS)));
    assign st.is_query    = func_reg;
    assign st.root        = (n_reg == NW'(1));
    assign st.n_odd       = n_reg[0];
    assign st.d_leaf      = d_reg[AW];
    assign st.rd_nz       = rd_nz;
    assign st.want_second = nfound_reg && !second_reg;

    assign fits = fits_reg;
    assign done = done_reg;

    // memory port select
    always_comb
    begin
        we    = 1'b0;
        wdata = val_reg;
        addr  = n_reg;
        if (cmd.upd_rd)
        begin
            addr = n_reg ^ NW'(1);
        end
        case (cmd.op)
            OP_CLR:
            begin
                we    = 1'b1;
                wdata = '0;
                addr  = clr_reg;
            end
            OP_LEAF_RD: addr = {1'b1, p_reg};
            OP_UP:      addr = n_reg - NW'(1);
            OP_DN:      addr = {d_reg[NW-2:0], 1'b1};
            OP_SUP:     addr = n_reg + NW'(1);
            OP_SDN:     addr = {d_reg[NW-2:0], 1'b0};
            OP_UPD_WR:  we   = 1'b1;
            default:    ;
        endcase
    end

    always_comb
    begin
        clr_next    = clr_reg;
        found_next  = found_reg;
        nfound_next = nfound_reg;
        second_next = second_reg;
        done_next   = 1'b0;
        func_next   = func_reg;
        pos_next    = pos_reg;
        size_next   = size_reg;
        p_next      = p_reg;
        pre_next    = pre_reg;
        nxt_next    = nxt_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        best_next   = best_reg;
        val_next    = val_reg;
        fits_next   = fits_reg;
        case (cmd.op)
            OP_CLR:
            begin
                clr_next = clr_reg + NW'(1);
            end
            OP_LOAD:
            begin
                func_next   = func;
                pos_next    = position;
                size_next   = block_size;
                p_next      = clamp32[AW-1:0];
                n_next      = {1'b1, clamp32[AW-1:0]};
                d_next      = {1'b1, AW'(0)};
                found_next  = 1'b0;
                nfound_next = 1'b0;
            end
            OP_LEAF_CHK:
            begin
                best_next = rdata;
                if (rd_nz)
                begin
                    d_next     = {1'b1, p_reg};
                    found_next = 1'b1;
                end
            end
            OP_UP:
            begin
                if (n_reg != NW'(1) && !n_reg[0])
                begin
                    n_next = n_reg >> 1;
                end
            end
            OP_UP_CHK:
            begin
                if (rdata > best_reg)
                begin
                    best_next = rdata;
                end
                if (rd_nz && !found_reg)
                begin
                    d_next     = n_reg - NW'(1);
                    found_next = 1'b1;
                end
                n_next = n_reg >> 1;
            end
            OP_DN:
            begin
                if (d_reg[AW])
                begin
                    pre_next = pre_new;
                    n_next   = {1'b1, p_reg};
                end
            end
            OP_DN_CHK:
            begin
                d_next = {d_reg[NW-2:0], rd_nz};
            end
            OP_EMIT:
            begin
                fits_next = (top >= size_reg);
                done_next = 1'b1;
            end
            OP_SUP:
            begin
                if (n_reg == NW'(1))
                begin
                    n_next      = {1'b1, p_reg};
                    val_next    = GAP_W'(32'(pos_reg) - 32'(pre_reg));
                    second_next = 1'b0;
                end
                else if (n_reg[0])
                begin
                    n_next = n_reg >> 1;
                end
            end
            OP_SUP_CHK:
            begin
                if (rd_nz)
                begin
                    d_next      = n_reg + NW'(1);
                    nfound_next = 1'b1;
                end
                else
                begin
                    n_next = n_reg >> 1;
                end
            end
            OP_SDN:
            begin
                if (d_reg[AW])
                begin
                    nxt_next    = nxt_new;
                    n_next      = {1'b1, p_reg};
                    val_next    = gap1;
                    second_next = 1'b0;
                end
            end
            OP_SDN_CHK:
            begin
                d_next = {d_reg[NW-2:0], !rd_nz};
            end
            OP_UPD_WR:
            begin
                // successor leaf gets its gap once the new obstacle is in
                if (n_reg == NW'(1) && nfound_reg && !second_reg)
                begin
                    second_next = 1'b1;
                    n_next      = {1'b1, nxt_reg};
                    val_next    = gap2;
                end
            end
            OP_UPD_CHK:
            begin
                if (rdata > val_reg)
                begin
                    val_next = rdata;
                end
                n_next = n_reg >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            found_reg  <= 1'b0;
            nfound_reg <= 1'b0;
            second_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            clr_reg    <= clr_next;
            found_reg  <= found_next;
            nfound_reg <= nfound_next;
            second_reg <= second_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        pos_reg  <= pos_next;
        size_reg <= size_next;
        p_reg    <= p_next;
        pre_reg  <= pre_next;
        nxt_reg  <= nxt_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        best_reg <= best_next;
        val_reg  <= val_next;
        fits_reg <= fits_next;
    end

endmodule

[src/ogfq_checker.sv]
// ----------------------------------------------------------------------------
// ogfq_checker
// Port-level timing checks for the obstacle gap fit block.
// ----------------------------------------------------------------------------
module ogfq_checker
    import ogfq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             func,
    input logic [POS_W-1:0] position,
    input logic [POS_W-1:0] block_size,
    input logic             done,
    input logic             fits
);

    // a result shows only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // a query request always makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func) |=> busy)
        else $error("query not taken up");

    // no result right after a request is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early");

    // one pulse per result
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

endmodule

bind obstacle_gap_fit_query_top ogfq_checker u_chk (.*);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Places obstacles and asks block fit questions on obstacle_gap_fit_query_top.
// A behavioral copy of the obstacle set and gap tree predicts every answer.
// ----------------------------------------------------------------------------
module tb_top
    import ogfq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POSITIONS = 4096;
    localparam int WATCHDOG  = 40000;

    typedef enum logic { FUNC_PLACE = 1'b0, FUNC_QUERY = 1'b1 } func_e;

    // scoreboard: obstacle set, gap leaves and queue of expected answers
    class fit_scoreboard;
        bit               occupied [POSITIONS];
        logic [GAP_W-1:0] gap_of [POSITIONS];
        bit               fit_queue [$];
        int               errors;

        function void clear();
            foreach (occupied[i])
            begin
                occupied[i] = 0;
                gap_of[i] = '0;
            end
            occupied[0] = 1;
            errors = 0;
        endfunction

        function int nearest_below(int pos);
            int p;
            p = (pos < POSITIONS) ? pos : POSITIONS - 1;
            while (p > 0 && !occupied[p])
                p--;
            return p;
        endfunction

        // note an accepted request, update state, queue the answer if any
        function void note_request(func_e f, int pos, int size);
            int pre;
            int best;
            if (f == FUNC_PLACE)
            begin
                if (pos >= POSITIONS || occupied[pos])
                    return;
                pre = nearest_below(pos);
                gap_of[pos] = GAP_W'(pos - pre);
                for (int n = pos + 1; n < POSITIONS; n++)
                begin
                    if (occupied[n])
                    begin
                        gap_of[n] = GAP_W'(n - pos);
                        break;
                    end
                end
                occupied[pos] = 1;
            end
            else
            begin
                pre = nearest_below(pos);
                best = pos - pre;
                for (int i = 0; i <= pre; i++)
                    if (gap_of[i] > best)
                        best = gap_of[i];
                fit_queue = {fit_queue, bit'(best >= size)};
            end
        endfunction

        function void check_answer(logic got);
            bit want;
            if (fit_queue.size() == 0)
            begin
                $error("fits: unexpected result, actual %0b", got);
                errors++;
                return;
            end
            want = fit_queue.pop_front();
            if (got !== want)
            begin
                $error("fits: expected %0b, actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             func;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] block_size;
    logic             done;
    logic             fits;

    fit_scoreboard board;
    int            idle_pct;
    int            stall_count;
    bit            timed_out;

    obstacle_gap_fit_query_top #(.POSITIONS(POSITIONS)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .position   (position),
        .block_size (block_size),
        .done       (done),
        .fits       (fits)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // results are sampled at the edge that ends the strobe cycle
    always @(posedge clk)
        if (rst_n && done)
            board.check_answer(fits);

    // watchdog counts cycles with neither a request nor a result taken
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // drive one request, holding start until the block takes it; start stays
    // high afterwards so requests can follow back to back
    task automatic send_request(func_e f, int pos, int size);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        position   <= pos[POS_W-1:0];
        block_size <= size[POS_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(f, pos, size);
    endtask

    // mostly small positions so obstacles crowd and gaps vary
    task automatic random_request();
        int pos;
        int size;
        pos = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(300);
        if (pos == 0 && $urandom_range(1))
            pos = 1;
        size = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(1, 120);
        if ($urandom_range(1))
            send_request(FUNC_QUERY, pos, size);
        else
            send_request(FUNC_PLACE, pos, size);
    endtask

    initial
    begin
        board = new();
        board.clear();
        stall_count = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = 1'b0;
        position    = '0;
        block_size  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty line, field extremes, repeated and zero places
        send_request(FUNC_QUERY, 0, 1);
        send_request(FUNC_QUERY, 0, 0);
        send_request(FUNC_QUERY, 4095, 4095);
        send_request(FUNC_QUERY, 4095, 4096 - 1);
        send_request(FUNC_QUERY, 1, 4095);
        send_request(FUNC_QUERY, 100, 0);
        send_request(FUNC_PLACE, 0, 5);
        send_request(FUNC_PLACE, 4095, 4095);
        send_request(FUNC_PLACE, 2048, 1);
        send_request(FUNC_PLACE, 2048, 1);
        send_request(FUNC_PLACE, 1, 0);
        send_request(FUNC_PLACE, 1024, 2730);
        send_request(FUNC_QUERY, 4095, 2047);
        send_request(FUNC_QUERY, 4095, 2048);
        send_request(FUNC_QUERY, 2047, 1023);
        send_request(FUNC_QUERY, 2047, 1024);
        send_request(FUNC_QUERY, 1, 1);
        send_request(FUNC_QUERY, 1, 2);
        send_request(FUNC_PLACE, 3000, 1365);
        send_request(FUNC_QUERY, 3500, 1048);
        send_request(FUNC_QUERY, 3500, 1500);

        // random phases: no idling, heavy idling, light idling, heavy idling
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1 || phase == 3) ? 58 : ((phase == 2) ? 20 : 0);
            for (int k = 0; k < 220; k++)
                random_request();
        end
        start <= 1'b0;

        // drain the outstanding answers, then the query latency
        while (board.fit_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
